/* rtl/core/crft_pkg.sv */
// Package for the CAN frame router and seen-id tracker.
// Holds widths, table size, route and register codes, and the compare result type.
// No dependencies.
package crft_pkg;

	localparam int TABLE_ENTRIES = 6;
	localparam int SEEN_PORTS    = 6;
	localparam int ID_W          = 11;
	localparam int DATA_W        = 64;
	localparam int THR_W         = 16;
	localparam int CFG_W         = 16;
	localparam int IDX_W         = 3;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES);

	typedef logic [ID_W-1:0] id_t;

	// Destination codes.
	typedef enum logic [1:0] {
		ROUTE_MOTOR = 2'd0,
		ROUTE_IMU   = 2'd1,
		ROUTE_DROP  = 2'd2
	} route_t;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_MOTOR_LOW  = 3'd0,
		REG_MOTOR_HIGH = 3'd1,
		REG_GYRO_ID    = 3'd2,
		REG_ACCEL_ID   = 3'd3,
		REG_BLINK_THR  = 3'd4
	} reg_idx_t;

	localparam id_t             RST_MOTOR_LOW  = 11'h201;
	localparam id_t             RST_MOTOR_HIGH = 11'h208;
	localparam id_t             RST_GYRO_ID    = 11'h100;
	localparam id_t             RST_ACCEL_ID   = 11'h101;
	localparam logic [THR_W-1:0] RST_BLINK_THR = 16'd200;

	// Result of the shared compare unit.
	typedef struct packed {
		logic eq;
		id_t  lo;
		id_t  hi;
	} cmp_res_t;

endpackage

/* rtl/core/crft_cmp.sv */
// Shared id compare unit: equality plus ordered minimum and maximum of two ids.
// Depends on crft_pkg.
module crft_cmp (
	input  crft_pkg::id_t     a,
	input  crft_pkg::id_t     b,
	output crft_pkg::cmp_res_t res
);
	import crft_pkg::*;

	logic a_lt_b;

	// One magnitude compare orders the merge steps; the equality compare serves the search.
	always_comb begin
		a_lt_b = (a < b);
		res.eq = (a == b);
		res.lo = a_lt_b ? a : b;
		res.hi = a_lt_b ? b : a;
	end

endmodule

/* rtl/core/can_frame_router_id_tracker.sv */
// CAN frame router with a sorted table of seen ids.
// Sequence: an accept step, a search over every table entry, a merge over every entry when the
// id is new, then a done step that loads the output register once it is free.
// A new frame is stalled until the done step ends; the single shared compare unit walks the table.
// Reset (arst_n low) empties the table, clears flags and counter, and loads register defaults.
module can_frame_router_id_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [crft_pkg::IDX_W-1:0]          wr_index,
	input  logic [crft_pkg::CFG_W-1:0]          wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  crft_pkg::id_t                       frame_id,
	input  logic [crft_pkg::DATA_W-1:0]         frame_data,
	input  logic [1:0]                          imu_flag_clear,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          route,
	output crft_pkg::id_t                       out_id,
	output logic [crft_pkg::DATA_W-1:0]         out_data,
	output logic [1:0]                          imu_flags,
	output logic                                led_toggle,
	output crft_pkg::id_t                       seen_id_0,
	output crft_pkg::id_t                       seen_id_1,
	output crft_pkg::id_t                       seen_id_2,
	output crft_pkg::id_t                       seen_id_3,
	output crft_pkg::id_t                       seen_id_4,
	output crft_pkg::id_t                       seen_id_5
);
	import crft_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SORT,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	id_t                tbl_q [TABLE_ENTRIES];
	id_t                carry_q;
	logic               seen_q;
	id_t                id_q;
	logic [DATA_W-1:0]  data_q;
	logic [1:0]         route_q;
	logic [1:0]         flags_q;
	logic               led_q;
	logic [THR_W-1:0]   frame_cnt_q;

	id_t                motor_low_q;
	id_t                motor_high_q;
	id_t                gyro_id_q;
	id_t                accel_id_q;
	logic [THR_W-1:0]   blink_thr_q;

	logic               out_valid_q;
	logic [1:0]         out_route_q;
	id_t                out_id_q;
	logic [DATA_W-1:0]  out_data_q;
	logic [1:0]         out_flags_q;
	logic               out_led_q;
	id_t                out_seen_q [SEEN_PORTS];

	id_t                cmp_a;
	id_t                cmp_b;
	cmp_res_t           cmp_res;
	logic               accept;
	logic               out_free;
	logic               last_step;
	logic               led_next;
	route_t             route_next;
	logic [1:0]         flags_next;
	logic               tbl_sorted;

	// Configuration registers; writes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_low_q  <= RST_MOTOR_LOW;
			motor_high_q <= RST_MOTOR_HIGH;
			gyro_id_q    <= RST_GYRO_ID;
			accel_id_q   <= RST_ACCEL_ID;
			blink_thr_q  <= RST_BLINK_THR;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MOTOR_LOW:  motor_low_q  <= wr_data[ID_W-1:0];
				REG_MOTOR_HIGH: motor_high_q <= wr_data[ID_W-1:0];
				REG_GYRO_ID:    gyro_id_q    <= wr_data[ID_W-1:0];
				REG_ACCEL_ID:   accel_id_q   <= wr_data[ID_W-1:0];
				REG_BLINK_THR:  blink_thr_q  <= wr_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake and the per-frame decisions made at accept time.
	always_comb begin
		accept    = in_valid && !in_stall;
		out_free  = !out_valid_q || !out_stall;
		last_step = (cnt_q == CNT_W'(TABLE_ENTRIES - 1));
		led_next  = (frame_cnt_q > blink_thr_q);
		if (frame_id >= motor_low_q && frame_id <= motor_high_q) begin
			route_next = ROUTE_MOTOR;
		end else if (frame_id == gyro_id_q || frame_id == accel_id_q) begin
			route_next = ROUTE_IMU;
		end else begin
			route_next = ROUTE_DROP;
		end
		flags_next = flags_q & ~imu_flag_clear;
		if (frame_id == gyro_id_q) begin
			flags_next[0] = 1'b1;
		end else if (frame_id == accel_id_q) begin
			flags_next[1] = 1'b1;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Operand select for the shared compare unit: probe during search, merge during sort.
	always_comb begin
		if (state_q == ST_SORT) begin
			cmp_a = carry_q;
			cmp_b = tbl_q[1];
		end else begin
			cmp_a = tbl_q[0];
			cmp_b = id_q;
		end
	end

	crft_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// Sequencer, table, and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			carry_q     <= '0;
			seen_q      <= 1'b0;
			id_q        <= '0;
			data_q      <= '0;
			route_q     <= ROUTE_DROP;
			flags_q     <= '0;
			led_q       <= 1'b0;
			frame_cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_route_q <= ROUTE_DROP;
			out_id_q    <= '0;
			out_data_q  <= '0;
			out_flags_q <= '0;
			out_led_q   <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				tbl_q[i] <= '0;
			end
			for (int k = 0; k < SEEN_PORTS; k++) begin
				out_seen_q[k] <= '0;
			end
		end else begin
			// The done step reloads the output register itself when it is taken.
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						id_q        <= frame_id;
						data_q      <= frame_data;
						route_q     <= route_next;
						flags_q     <= flags_next;
						led_q       <= led_next;
						frame_cnt_q <= (led_next ? '0 : frame_cnt_q) + 1'b1;
						seen_q      <= 1'b0;
						cnt_q       <= '0;
						state_q     <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// Rotate the table past the probe at entry 0; a full turn restores it.
					for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
						tbl_q[i] <= tbl_q[i + 1];
					end
					tbl_q[TABLE_ENTRIES - 1] <= tbl_q[0];
					seen_q <= seen_q || cmp_res.eq;
					if (last_step) begin
						cnt_q   <= '0;
						carry_q <= id_q;
						state_q <= (seen_q || cmp_res.eq) ? ST_DONE : ST_SORT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SORT: begin
					if (last_step) begin
						// Close the merge: drop the replaced smallest entry, append the carry.
						for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
							tbl_q[i] <= tbl_q[i + 1];
						end
						tbl_q[TABLE_ENTRIES - 1] <= carry_q;
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						// Emit the smaller of carry and the next entry to the tail.
						for (int i = 1; i < TABLE_ENTRIES - 1; i++) begin
							tbl_q[i] <= tbl_q[i + 1];
						end
						tbl_q[TABLE_ENTRIES - 1] <= cmp_res.lo;
						carry_q <= cmp_res.hi;
						cnt_q   <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_route_q <= route_q;
						out_id_q    <= (route_q == ROUTE_DROP) ? '0 : id_q;
						out_data_q  <= (route_q == ROUTE_DROP) ? '0 : data_q;
						out_flags_q <= flags_q;
						out_led_q   <= led_q;
						for (int k = 0; k < SEEN_PORTS; k++) begin
							out_seen_q[k] <= (k < TABLE_ENTRIES) ? tbl_q[k] : '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign route      = out_route_q;
	assign out_id     = out_id_q;
	assign out_data   = out_data_q;
	assign imu_flags  = out_flags_q;
	assign led_toggle = out_led_q;
	assign seen_id_0  = out_seen_q[0];
	assign seen_id_1  = out_seen_q[1];
	assign seen_id_2  = out_seen_q[2];
	assign seen_id_3  = out_seen_q[3];
	assign seen_id_4  = out_seen_q[4];
	assign seen_id_5  = out_seen_q[5];

	// The table stays in ascending order between transactions.
	always_comb begin
		tbl_sorted = 1'b1;
		for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
			if (tbl_q[i] > tbl_q[i + 1]) begin
				tbl_sorted = 1'b0;
			end
		end
	end

	a_sorted_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> tbl_sorted)
		else $error("seen table out of order while idle");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output loaded outside the done step");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_route_q == ROUTE_DROP |-> out_id_q == '0 && out_data_q == '0)
		else $error("dropped frame carries a record");

	a_route_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_route_q == ROUTE_MOTOR || out_route_q == ROUTE_IMU
			|| out_route_q == ROUTE_DROP)
		else $error("invalid route code on output");

	a_sort_only_new: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SORT |-> !seen_q)
		else $error("table merge started for an id already present");

endmodule

/* tb/can_frame_router_id_tracker_checker.sv */
// Checker for the CAN frame router: watches the register port and both channels,
// predicts each result and compares it with what the block returns.
// Depends on crft_pkg for widths, route codes and register indexes.
`timescale 1ns / 100ps

module can_frame_router_id_tracker_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [crft_pkg::IDX_W-1:0]  wr_index,
	input  logic [crft_pkg::CFG_W-1:0]  wr_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  crft_pkg::id_t               frame_id,
	input  logic [crft_pkg::DATA_W-1:0] frame_data,
	input  logic [1:0]                  imu_flag_clear,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  route,
	input  crft_pkg::id_t               out_id,
	input  logic [crft_pkg::DATA_W-1:0] out_data,
	input  logic [1:0]                  imu_flags,
	input  logic                        led_toggle,
	input  crft_pkg::id_t               seen_id_0,
	input  crft_pkg::id_t               seen_id_1,
	input  crft_pkg::id_t               seen_id_2,
	input  crft_pkg::id_t               seen_id_3,
	input  crft_pkg::id_t               seen_id_4,
	input  crft_pkg::id_t               seen_id_5,
	output int                          errors,
	output int                          outstanding
);
	import crft_pkg::*;

	// One routed frame as the block should report it.
	typedef struct packed {
		route_t                 dest;
		id_t                    id;
		logic [DATA_W-1:0]      data;
		logic [1:0]             flags;
		logic                   led;
		id_t [SEEN_PORTS-1:0]   seen;
	} frame_result_t;

	// Shadow copy of the registers and of the block's state.
	id_t              motor_lo;
	id_t              motor_hi;
	id_t              cfg_gyro;
	id_t              cfg_accel;
	logic [THR_W-1:0] cfg_thr;
	id_t              seen_tab [TABLE_ENTRIES];
	logic [1:0]       upd_flags;
	logic [THR_W-1:0] frame_cnt;

	frame_result_t    expected_frames [$];
	frame_result_t    want;
	id_t [SEEN_PORTS-1:0] seen_now;

	assign seen_now = {seen_id_5, seen_id_4, seen_id_3, seen_id_2, seen_id_1, seen_id_0};

	// Advance the shadow state by one frame and return the result it should produce.
	function automatic frame_result_t route_frame(input id_t id, input logic [DATA_W-1:0] data,
			input logic [1:0] clr);
		frame_result_t r;
		logic          hit;
		id_t           tmp;
		upd_flags = upd_flags & ~clr;
		r.led = 1'b0;
		if (frame_cnt > cfg_thr) begin
			r.led = 1'b1;
			frame_cnt = '0;
		end
		if (id >= motor_lo && id <= motor_hi)
			r.dest = ROUTE_MOTOR;
		else if (id == cfg_gyro || id == cfg_accel)
			r.dest = ROUTE_IMU;
		else
			r.dest = ROUTE_DROP;
		frame_cnt = frame_cnt + 1'b1;
		// Gyro wins when both ids are the same.
		if (id == cfg_gyro)
			upd_flags = upd_flags | 2'b01;
		else if (id == cfg_accel)
			upd_flags = upd_flags | 2'b10;
		// An unseen id replaces the smallest entry, then it bubbles up to its place.
		hit = 1'b0;
		for (int k = 0; k < TABLE_ENTRIES; k++)
			if (seen_tab[k] == id)
				hit = 1'b1;
		if (!hit)
			seen_tab[0] = id;
		for (int k = 1; k < TABLE_ENTRIES; k++) begin
			if (seen_tab[k-1] > seen_tab[k]) begin
				tmp = seen_tab[k];
				seen_tab[k] = seen_tab[k-1];
				seen_tab[k-1] = tmp;
			end
		end
		r.id = (r.dest == ROUTE_DROP) ? '0 : id;
		r.data = (r.dest == ROUTE_DROP) ? '0 : data;
		r.flags = upd_flags;
		for (int k = 0; k < SEEN_PORTS; k++)
			r.seen[k] = (k < TABLE_ENTRIES) ? seen_tab[k] : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
			input logic [DATA_W-1:0] act_val);
		if (exp_val !== act_val) begin
			if (errors < 10)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
					exp_val, act_val);
			errors++;
		end
	endtask

	// Track register writes, predict on accepted frames, compare on accepted results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_lo = RST_MOTOR_LOW;
			motor_hi = RST_MOTOR_HIGH;
			cfg_gyro = RST_GYRO_ID;
			cfg_accel = RST_ACCEL_ID;
			cfg_thr = RST_BLINK_THR;
			for (int k = 0; k < TABLE_ENTRIES; k++)
				seen_tab[k] = '0;
			upd_flags = '0;
			frame_cnt = '0;
			expected_frames.delete();
			outstanding <= 0;
		end else begin
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_MOTOR_LOW:  motor_lo = wr_data[ID_W-1:0];
					REG_MOTOR_HIGH: motor_hi = wr_data[ID_W-1:0];
					REG_GYRO_ID:    cfg_gyro = wr_data[ID_W-1:0];
					REG_ACCEL_ID:   cfg_accel = wr_data[ID_W-1:0];
					REG_BLINK_THR:  cfg_thr = wr_data[THR_W-1:0];
					default: ;
				endcase
			end
			// A result leaving now belongs to an earlier transaction, so compare first.
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					if (errors < 10)
						$display("%0t: result transaction with nothing expected", $time);
					errors++;
				end else begin
					want = expected_frames.pop_front();
					check_field("route", DATA_W'(want.dest), DATA_W'(route));
					check_field("out_id", DATA_W'(want.id), DATA_W'(out_id));
					check_field("out_data", want.data, out_data);
					check_field("imu_flags", DATA_W'(want.flags), DATA_W'(imu_flags));
					check_field("led_toggle", DATA_W'(want.led), DATA_W'(led_toggle));
					for (int k = 0; k < SEEN_PORTS; k++)
						check_field($sformatf("seen_id_%0d", k), DATA_W'(want.seen[k]),
							DATA_W'(seen_now[k]));
				end
			end
			if (in_valid && !in_stall)
				expected_frames.push_back(route_frame(frame_id, frame_data, imu_flag_clear));
			outstanding <= expected_frames.size();
		end
	end

endmodule

/* tb/can_frame_router_id_tracker_tb.sv */
// Top of the CAN frame router testbench: clock, reset, register setup and frame stimulus
// with random gaps and output stalls; the verdict comes from the checker's error count.
// Depends on crft_pkg, can_frame_router_id_tracker and can_frame_router_id_tracker_checker.
`timescale 1ns / 100ps

module can_frame_router_id_tracker_tb;
	import crft_pkg::*;

	localparam int LIMIT     = 500000;
	localparam int POOL_SIZE = 8;
	localparam int DIR_N     = 16;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 in_valid;
	logic                 in_stall;
	id_t                  frame_id;
	logic [DATA_W-1:0]    frame_data;
	logic [1:0]           imu_flag_clear;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           route;
	id_t                  out_id;
	logic [DATA_W-1:0]    out_data;
	logic [1:0]           imu_flags;
	logic                 led_toggle;
	id_t                  seen_id_0, seen_id_1, seen_id_2, seen_id_3, seen_id_4, seen_id_5;
	int                   errors;
	int                   outstanding;
	int                   cycle_cnt = 0;

	// Register values currently loaded, used to aim the random ids.
	id_t                  cur_lo = RST_MOTOR_LOW;
	id_t                  cur_hi = RST_MOTOR_HIGH;
	id_t                  cur_gyro = RST_GYRO_ID;
	id_t                  cur_accel = RST_ACCEL_ID;
	id_t                  id_pool [POOL_SIZE];
	bit                   calm = 1'b0;

	// Directed frames at the reset settings: range edges, gyro and accel, id zero,
	// the largest id, flag clears and an id zero arriving once the table is full.
	id_t dir_id [DIR_N] = '{11'h000, 11'h201, 11'h208, 11'h200, 11'h209, 11'h100,
		11'h101, 11'h7FF, 11'h100, 11'h555, 11'h2AA, 11'h204, 11'h201, 11'h000,
		11'h101, 11'h123};
	logic [DATA_W-1:0] dir_data [DIR_N] = '{64'h0, {DATA_W{1'b1}}, 64'h0123456789ABCDEF,
		64'hFEDCBA9876543210, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
		64'h8000000000000001, 64'h7FFFFFFFFFFFFFFE, 64'hFFFFFFFF00000000,
		64'h00000000FFFFFFFF, 64'hDEADBEEFCAFEF00D, 64'h1, 64'h8000000000000000,
		64'h0F0F0F0F0F0F0F0F, 64'hF0F0F0F0F0F0F0F0, 64'h0123456789ABCDEF};
	logic [1:0] dir_clr [DIR_N] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0,
		2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd0, 2'd3, 2'd0};

	can_frame_router_id_tracker dut (.*);

	can_frame_router_id_tracker_checker u_checker (.*);

	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic id_t pick_id();
		int p;
		p = $urandom_range(0, 99);
		if (p < 25)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (p < 38)
			return cur_gyro;
		if (p < 50)
			return cur_accel;
		if (p < 68)
			return (cur_lo <= cur_hi) ? id_t'($urandom_range(cur_hi, cur_lo)) : cur_lo;
		if (p < 80) begin
			case ($urandom_range(0, 5))
				0: return '0;
				1: return '1;
				2: return cur_lo - 1'b1;
				3: return cur_hi + 1'b1;
				4: return cur_lo;
				default: return cur_hi;
			endcase
		end
		return id_t'($urandom_range(0, 2047));
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		int p;
		p = $urandom_range(0, 99);
		if (p < 8)
			return '0;
		if (p < 16)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Offer one frame, hold it until accepted, then maybe leave a gap.
	task automatic send_frame(input id_t id, input logic [DATA_W-1:0] data,
			input logic [1:0] clr);
		int gap;
		frame_id <= id;
		frame_data <= data;
		imu_flag_clear <= clr;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
	endtask

	// Write all registers back to back; only called while the block is idle.
	task automatic load_config(input id_t lo, input id_t hi, input id_t gy, input id_t ac,
			input logic [THR_W-1:0] thr);
		put_reg(REG_MOTOR_LOW, CFG_W'(lo));
		put_reg(REG_MOTOR_HIGH, CFG_W'(hi));
		put_reg(REG_GYRO_ID, CFG_W'(gy));
		put_reg(REG_ACCEL_ID, CFG_W'(ac));
		put_reg(REG_BLINK_THR, thr);
		wr_en <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
		cur_gyro = gy;
		cur_accel = ac;
	endtask

	// Random frames over a small id pool, so the table sees both hits and evictions.
	task automatic run_frames(input int n_frames);
		for (int k = 0; k < POOL_SIZE; k++)
			id_pool[k] = (k % 2 == 0 || cur_lo > cur_hi) ? id_t'($urandom_range(0, 2047))
				: id_t'($urandom_range(cur_hi, cur_lo));
		for (int k = 0; k < n_frames; k++)
			send_frame(pick_id(), pick_data(), 2'($urandom_range(0, 3)));
		drain();
	endtask

	// Output side stalls at random once reset is released.
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Main stimulus and verdict.
	initial begin
		id_t lo;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		frame_id = '0;
		frame_data = '0;
		imu_flag_clear = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: directed frames, then enough random ones to pass the blink count.
		for (int k = 0; k < DIR_N; k++)
			send_frame(dir_id[k], dir_data[k], dir_clr[k]);
		run_frames(200);

		// Every id goes to the motor queue; threshold zero blinks on every frame.
		load_config(11'd0, 11'h7FF, 11'd5, 11'h7FE, 16'd0);
		run_frames(140);

		// Inverted range: nothing is motor; gyro on id zero.
		load_config(11'h7FF, 11'd0, 11'd0, 11'h7FF, 16'd3);
		run_frames(140);

		// Gyro and accel share one id inside the motor range; the LED never blinks.
		load_config(11'h300, 11'h30F, 11'h305, 11'h305, 16'hFFFF);
		run_frames(140);

		// Single-id motor range with neighbours as gyro and accel, no idling at all.
		calm = 1'b1;
		load_config(11'h400, 11'h400, 11'h3FF, 11'h401, 16'd10);
		run_frames(120);
		calm = 1'b0;

		// Random narrow range and small threshold.
		lo = id_t'($urandom_range(0, 2047));
		load_config(lo, (lo > 11'h7D7) ? 11'h7FF : lo + id_t'($urandom_range(0, 40)),
			id_t'($urandom_range(0, 2047)), id_t'($urandom_range(0, 2047)),
			THR_W'($urandom_range(0, 40)));
		run_frames(100);

		// Back to the reset values.
		load_config(RST_MOTOR_LOW, RST_MOTOR_HIGH, RST_GYRO_ID, RST_ACCEL_ID, RST_BLINK_THR);
		run_frames(100);

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
